// File: rtl/pwmfdp_pkg.sv
package pwmfdp_pkg;

  localparam int CHANNELS = 4;
  localparam int BANDS    = 10;

  localparam int DIV_W  = 36;
  localparam int CLK_W  = 28;
  localparam int FREQ_W = 36;
  localparam int DUTY_W = 17;

  localparam logic [15:0] CAP16    = 16'hFFFF;
  localparam logic [16:0] DUTY_ONE = 17'd65536;

  localparam logic [CLK_W-1:0]  CLOCK_HZ_RST = 28'd108000000;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 36'd256;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 36'd5120000;

  // band exponents of the period and of the prescaler
  localparam logic [4:0] ARR_EXP [16] = '{
    5'd16, 5'd16, 5'd14, 5'd14, 5'd10, 5'd10, 5'd6, 5'd6,
    5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2, 5'd2
  };
  localparam logic [4:0] PSC_EXP [16] = '{
    5'd16, 5'd8, 5'd8, 5'd6, 5'd6, 5'd4, 5'd4, 5'd2,
    5'd2,  5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
  };

  localparam logic [1:0] MODE_FREQ = 2'd0;
  localparam logic [1:0] MODE_DUTY = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [1:0] CFG_FREQ_MIN = 2'd1;
  localparam logic [1:0] CFG_FREQ_MAX = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        channel;
    logic [FREQ_W-1:0] target_freq;
    logic [DUTY_W-1:0] duty_value;
  } item_t;

  typedef struct packed {
    logic [1:0]        out_channel;
    logic [15:0]       prescaler;
    logic [15:0]       period;
    logic [15:0]       compare;
    logic              counter_reset;
    logic [DUTY_W-1:0] duty_read;
    logic [FREQ_W-1:0] freq_read;
    logic              last;
  } result_t;

  function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
    logic [15:0] r;
    r = (v > DIV_W'(CAP16)) ? CAP16 : v[15:0];
    return r;
  endfunction

endpackage

// File: rtl/pwm_frequency_duty_programmer.sv
// Channel  | Handshake                 | Payload
// item     | item_valid / item_stall   | item (mode, channel, target_freq, duty_value)
// result   | result_valid / result_stall | result (one per channel on a frequency write)
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One 36-step restoring divider and one 17x17 multiplier are shared under a sequencer.
// Frequency write: a band search, the period divide, a rescaling divide per channel when
// the period changes, and a frequency divide and a duty divide per emitted channel.
// Duty write and read: the divider sets nearly all of their time.
// A result waits in an output register; the next item is taken while it waits.
// rst is synchronous, active high, and restores the configuration reset values.
module pwm_frequency_duty_programmer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  pwmfdp_pkg::item_t          item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output pwmfdp_pkg::result_t        result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [pwmfdp_pkg::FREQ_W-1:0] cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_BAND     = 14'b00000000000010,
    S_DIV      = 14'b00000000000100,
    S_FREQ_SET = 14'b00000000001000,
    S_FREQ_CHK = 14'b00000000010000,
    S_RS_MUL   = 14'b00000000100000,
    S_RS_LOAD  = 14'b00000001000000,
    S_RS_STORE = 14'b00000010000000,
    S_DUTY_MUL = 14'b00000100000000,
    S_DUTY_SET = 14'b00001000000000,
    S_EM_MUL   = 14'b00010000000000,
    S_EM_LOADF = 14'b00100000000000,
    S_EM_LOADD = 14'b01000000000000,
    S_EM_OUT   = 14'b10000000000000
  } state_t;

  state_t state;
  state_t div_ret;

  logic [pwmfdp_pkg::CLK_W-1:0]  clock_hz;
  logic [pwmfdp_pkg::FREQ_W-1:0] freq_min;
  logic [pwmfdp_pkg::FREQ_W-1:0] freq_max;

  logic [15:0] period_reg;
  logic [15:0] prescaler_reg;
  logic [15:0] compare_regs [4];
  logic [15:0] newp;

  logic [pwmfdp_pkg::FREQ_W-1:0] fre;
  logic [pwmfdp_pkg::DUTY_W-1:0] duty;
  logic [1:0]  chan;
  logic        multi;
  logic        changed;
  logic [3:0]  band;
  logic        fixed_per;
  logic [pwmfdp_pkg::FREQ_W-1:0] freq_q;

  logic [pwmfdp_pkg::DIV_W-1:0] div_rem;
  logic [pwmfdp_pkg::DIV_W-1:0] div_quo;
  logic [pwmfdp_pkg::DIV_W-1:0] div_den;
  logic [5:0]                   div_cnt;
  logic [pwmfdp_pkg::DIV_W:0]   rem_sh;
  logic                         rem_ge;
  logic [pwmfdp_pkg::DIV_W-1:0] rem_next;

  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;

  pwmfdp_pkg::result_t result_reg;
  logic        result_reg_valid;
  logic        take;
  logic        emit_fire;
  logic [pwmfdp_pkg::FREQ_W-1:0] fre_clamped;
  logic [pwmfdp_pkg::DIV_W-1:0]  xc;
  logic [pwmfdp_pkg::DIV_W-1:0]  thr;
  logic [5:0]  band_sh;
  logic [4:0]  res_sh;
  logic [pwmfdp_pkg::DIV_W-1:0]  q_sh;
  logic [pwmfdp_pkg::DIV_W-1:0]  q_m1;
  logic [15:0] pow_m1;
  logic [16:0] p1;
  logic [16:0] ps1;
  logic [16:0] n1;
  logic        chan_ok;
  logic [15:0] c_emit;
  logic        last_emit;

  assign item_stall   = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_valid = result_reg_valid;
  assign result       = result_reg;
  assign take         = result_reg_valid && !result_stall;
  // load the output register when it is free or being emptied
  assign emit_fire    = (state == S_EM_OUT) && (!result_reg_valid || !result_stall);

  assign xc  = {clock_hz, 8'b0};
  assign p1  = {1'b0, period_reg} + 17'd1;
  assign ps1 = {1'b0, prescaler_reg} + 17'd1;
  assign n1  = {1'b0, newp} + 17'd1;

  always_comb begin
    if (item.target_freq < freq_min) begin
      fre_clamped = freq_min;
    end else if (item.target_freq > freq_max) begin
      fre_clamped = freq_max;
    end else begin
      fre_clamped = item.target_freq;
    end
  end

  assign band_sh = {1'b0, pwmfdp_pkg::ARR_EXP[band]} + {1'b0, pwmfdp_pkg::PSC_EXP[band]};
  assign thr     = xc >> band_sh;

  // divisor-quotient shaping once the band is known
  assign res_sh = fixed_per ? pwmfdp_pkg::ARR_EXP[band] : pwmfdp_pkg::PSC_EXP[band];
  assign q_sh   = div_quo >> res_sh;
  assign q_m1   = (q_sh == '0) ? '0 : q_sh - pwmfdp_pkg::DIV_W'(1);
  assign pow_m1 = 16'((17'd1 << res_sh) - 17'd1);

  assign chan_ok   = ({1'b0, chan} < 3'(pwmfdp_pkg::CHANNELS));
  assign c_emit    = chan_ok ? compare_regs[chan] : 16'd0;
  assign last_emit = !multi || (chan == 2'(pwmfdp_pkg::CHANNELS - 1));

  // shared restoring divider, one quotient bit per cycle
  assign rem_sh   = {div_rem, div_quo[pwmfdp_pkg::DIV_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_next = rem_ge ? pwmfdp_pkg::DIV_W'(rem_sh - {1'b0, div_den})
                           : rem_sh[pwmfdp_pkg::DIV_W-1:0];

  always_comb begin
    case (state)
      S_RS_MUL: begin
        mul_a = n1;
        mul_b = {1'b0, compare_regs[chan]};
      end
      S_DUTY_MUL: begin
        mul_a = p1;
        mul_b = duty;
      end
      default: begin
        mul_a = p1;
        mul_b = ps1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= pwmfdp_pkg::CLOCK_HZ_RST;
      freq_min <= pwmfdp_pkg::FREQ_MIN_RST;
      freq_max <= pwmfdp_pkg::FREQ_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwmfdp_pkg::CFG_CLOCK_HZ: clock_hz <= cfg_data[pwmfdp_pkg::CLK_W-1:0];
        pwmfdp_pkg::CFG_FREQ_MIN: freq_min <= cfg_data;
        pwmfdp_pkg::CFG_FREQ_MAX: freq_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      div_ret          <= S_IDLE;
      result_reg_valid <= 1'b0;
      period_reg       <= '0;
      prescaler_reg    <= '0;
      for (int i = 0; i < 4; i++) begin
        compare_regs[i] <= '0;
      end
    end else begin
      if (emit_fire) begin
        result_reg_valid <= 1'b1;
      end else if (take) begin
        result_reg_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            fre     <= fre_clamped;
            duty    <= item.duty_value;
            chan    <= item.channel;
            changed <= 1'b0;
            band    <= 4'd1;
            case (item.mode)
              pwmfdp_pkg::MODE_FREQ: begin
                multi <= 1'b1;
                state <= S_BAND;
              end
              pwmfdp_pkg::MODE_DUTY: begin
                multi <= 1'b0;
                if ({1'b0, item.channel} < 3'(pwmfdp_pkg::CHANNELS)) begin
                  state <= S_DUTY_MUL;
                end else begin
                  state <= S_EM_MUL;
                end
              end
              pwmfdp_pkg::MODE_READ: begin
                multi <= 1'b0;
                state <= S_EM_MUL;
              end
              default: state <= S_IDLE;  // drop undefined mode
            endcase
          end
        end
        S_BAND: begin
          if (fre <= thr) begin
            fixed_per <= (pwmfdp_pkg::ARR_EXP[band] == pwmfdp_pkg::ARR_EXP[band - 4'd1]);
            div_quo   <= xc;
            div_rem   <= '0;
            div_den   <= fre;
            div_cnt   <= 6'(pwmfdp_pkg::DIV_W - 1);
            div_ret   <= S_FREQ_SET;
            state     <= S_DIV;
          end else if (band == 4'(pwmfdp_pkg::BANDS - 1)) begin
            // above every threshold: period 0, prescaler kept
            newp  <= '0;
            state <= S_FREQ_CHK;
          end else begin
            band <= band + 4'd1;
          end
        end
        S_DIV: begin
          div_rem <= rem_next;
          div_quo <= {div_quo[pwmfdp_pkg::DIV_W-2:0], rem_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd0) begin
            state <= div_ret;
          end
        end
        S_FREQ_SET: begin
          if (fixed_per) begin
            newp          <= pow_m1;
            prescaler_reg <= pwmfdp_pkg::sat16(q_m1);
          end else begin
            prescaler_reg <= pow_m1;
            newp          <= pwmfdp_pkg::sat16(q_m1);
          end
          state <= S_FREQ_CHK;
        end
        S_FREQ_CHK: begin
          changed <= (newp != period_reg);
          chan    <= 2'd0;
          state   <= (newp != period_reg) ? S_RS_MUL : S_EM_MUL;
        end
        S_RS_MUL: begin
          state <= S_RS_LOAD;
        end
        S_RS_LOAD: begin
          div_quo <= pwmfdp_pkg::DIV_W'({prod, 1'b0}) + pwmfdp_pkg::DIV_W'(p1);
          div_rem <= '0;
          div_den <= pwmfdp_pkg::DIV_W'({p1, 1'b0});
          div_cnt <= 6'(pwmfdp_pkg::DIV_W - 1);
          div_ret <= S_RS_STORE;
          state   <= S_DIV;
        end
        S_RS_STORE: begin
          compare_regs[chan] <= pwmfdp_pkg::sat16(div_quo);
          if (chan == 2'(pwmfdp_pkg::CHANNELS - 1)) begin
            period_reg <= newp;
            chan       <= 2'd0;
            state      <= S_EM_MUL;
          end else begin
            chan  <= chan + 2'd1;
            state <= S_RS_MUL;
          end
        end
        S_DUTY_MUL: begin
          state <= S_DUTY_SET;
        end
        S_DUTY_SET: begin
          compare_regs[chan] <= pwmfdp_pkg::sat16(
            pwmfdp_pkg::DIV_W'((35'(prod) + 35'd32768) >> 16));
          state <= S_EM_MUL;
        end
        S_EM_MUL: begin
          state <= S_EM_LOADF;
        end
        S_EM_LOADF: begin
          div_quo <= xc;
          div_rem <= '0;
          div_den <= pwmfdp_pkg::DIV_W'(prod);
          div_cnt <= 6'(pwmfdp_pkg::DIV_W - 1);
          div_ret <= S_EM_LOADD;
          state   <= S_DIV;
        end
        S_EM_LOADD: begin
          freq_q  <= div_quo;
          div_quo <= pwmfdp_pkg::DIV_W'({c_emit, 17'b0}) + pwmfdp_pkg::DIV_W'(p1);
          div_rem <= '0;
          div_den <= pwmfdp_pkg::DIV_W'({p1, 1'b0});
          div_cnt <= 6'(pwmfdp_pkg::DIV_W - 1);
          div_ret <= S_EM_OUT;
          state   <= S_DIV;
        end
        S_EM_OUT: begin
          // hold until the output register is free or being emptied
          if (emit_fire) begin
            if (last_emit) begin
              state <= S_IDLE;
            end else begin
              chan  <= chan + 2'd1;
              state <= S_EM_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result_reg.out_channel   <= chan;
      result_reg.prescaler     <= prescaler_reg;
      result_reg.period        <= period_reg;
      result_reg.compare       <= c_emit;
      result_reg.counter_reset <= changed;
      result_reg.duty_read     <= (div_quo > pwmfdp_pkg::DIV_W'(pwmfdp_pkg::DUTY_ONE))
                                  ? pwmfdp_pkg::DUTY_ONE : div_quo[pwmfdp_pkg::DUTY_W-1:0];
      result_reg.freq_read     <= freq_q;
      result_reg.last          <= last_emit;
    end
  end

  a_duty_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.duty_read <= pwmfdp_pkg::DUTY_ONE)
    else $error("duty_read above full scale");

  a_div_return: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 6'd0) |=> state == $past(div_ret))
    else $error("divider did not return to its caller");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BAND |-> (band >= 4'd1 && band <= 4'(pwmfdp_pkg::BANDS - 1)))
    else $error("band index out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result transaction changed or dropped");

endmodule
